FILE: rtl/pwps_pkg.sv
`timescale 1ns / 1ps

package pwps_pkg;

    // Default sizes of the scheduler
    localparam int NUM_PARTITIONS_DEF      = 4;
    localparam int PROCS_PER_PARTITION_DEF = 8;

    // Widest partition and slot index over the supported parameter range
    localparam int PART_IDX_W = 4;
    localparam int SLOT_IDX_W = 6;

    // Operation codes
    localparam logic [1:0] OP_TIME_CHECK = 2'd0;
    localparam logic [1:0] OP_WRITE      = 2'd1;
    localparam logic [1:0] OP_SELECT     = 2'd2;
    localparam logic [1:0] OP_STOP       = 2'd3;

    // Process states
    localparam logic [1:0] ST_DORMANT = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;

    // Configuration register indexes
    localparam logic [2:0] CFG_PART_COUNT = 3'd0;
    localparam logic [2:0] CFG_WINDOW_0   = 3'd1;
    localparam logic [2:0] CFG_WINDOW_1   = 3'd2;
    localparam logic [2:0] CFG_WINDOW_2   = 3'd3;
    localparam logic [2:0] CFG_WINDOW_3   = 3'd4;

    // Configuration reset values
    localparam logic [2:0]  PART_COUNT_RST = 3'd4;
    localparam logic [15:0] WINDOW_SHORT   = 16'd1000;
    localparam logic [15:0] WINDOW_LONG    = 16'd3000;

    // Table update broadcast to every cell
    typedef struct packed {
        logic                  wr;
        logic                  clr;
        logic [PART_IDX_W-1:0] part;
        logic [SLOT_IDX_W-1:0] slot;
        logic [1:0]            state;
        logic [7:0]            prio;
        logic [31:0]           stamp;
    } t_cell_cmd;

    // Best-so-far token passed from cell to cell during a select
    typedef struct packed {
        logic                  valid;
        logic [PART_IDX_W-1:0] part;
        logic                  have;
        logic [SLOT_IDX_W-1:0] best;
        logic [7:0]            prio;
        logic [31:0]           stamp;
    } t_token;

endpackage

FILE: rtl/pwps_cell.sv
`timescale 1ns / 1ps

module pwps_cell #(
    parameter int NUM_PARTITIONS = pwps_pkg::NUM_PARTITIONS_DEF,
    parameter int CELL_IDX       = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pwps_pkg::t_cell_cmd i_cmd,
    input  pwps_pkg::t_token    i_tok,
    output pwps_pkg::t_token    o_tok
);
    import pwps_pkg::*;

    localparam int PW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

    // One process slot of every partition
    logic [1:0]  r_state [NUM_PARTITIONS];
    logic [7:0]  r_prio  [NUM_PARTITIONS];
    logic [31:0] r_stamp [NUM_PARTITIONS];
    t_token      r_tok;
    t_token      n_tok;

    logic          w_hit;
    logic [PW-1:0] w_cmd_part;
    logic [PW-1:0] w_tok_part;
    logic          w_ready;
    logic          w_take;

    assign w_hit      = (i_cmd.slot == SLOT_IDX_W'(CELL_IDX));
    assign w_cmd_part = i_cmd.part[PW-1:0];
    assign w_tok_part = i_tok.part[PW-1:0];

    // Update the slot state on a write or a stop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PARTITIONS; p++) begin
                r_state[p] <= ST_DORMANT;
            end
        end else if (w_hit && i_cmd.wr) begin
            r_state[w_cmd_part] <= i_cmd.state;
        end else if (w_hit && i_cmd.clr) begin
            r_state[w_cmd_part] <= ST_DORMANT;
        end
    end

    // Store priority and stamp on a write
    always_ff @(posedge i_clk) begin
        if (w_hit && i_cmd.wr) begin
            r_prio[w_cmd_part]  <= i_cmd.prio;
            r_stamp[w_cmd_part] <= i_cmd.stamp;
        end
    end

    // Compare this slot against the best so far; earlier slots win ties
    always_comb begin
        w_ready = (r_state[w_tok_part] == ST_READY);
        w_take  = w_ready && (!i_tok.have
                  || (r_prio[w_tok_part] > i_tok.prio)
                  || ((r_prio[w_tok_part] == i_tok.prio)
                      && (r_stamp[w_tok_part] < i_tok.stamp)));
    end

    // Replace the best so far with this slot when it wins
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && w_take) begin
            n_tok.have  = 1'b1;
            n_tok.best  = SLOT_IDX_W'(CELL_IDX);
            n_tok.prio  = r_prio[w_tok_part];
            n_tok.stamp = r_stamp[w_tok_part];
        end
    end

    // Advance the token to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: rtl/partition_window_process_scheduler_top.sv
`timescale 1ns / 1ps

// Two-level partition and process scheduler.
// Input words arrive on i_valid / o_ready with an operation code: time check,
// write process entry, select process, stop running process. Each word gives
// exactly one result word on o_valid / i_ready.
// The process table sits in a row of cells, one per process slot, each
// holding that slot for every partition. A select sends a best-so-far token
// down the row, one cell per cycle. A time check that switches partitions
// runs a subtract loop for the wrap of the partition counter.
// One word is worked on at a time; o_ready rises again once the result is in
// the output register, so the next word is taken while a result waits.
// When the receiver stalls, the result holds in the output register and the
// next word waits for it before its own result is loaded.
// Configuration writes (i_cfg_wen, i_cfg_index, i_cfg_wdata) take effect at
// once and belong in idle time. Reset sets partition 0 active, deadline 0, all
// processes dormant and the registers to their defaults; no clearing pass.
module partition_window_process_scheduler_top #(
    parameter int NUM_PARTITIONS      = pwps_pkg::NUM_PARTITIONS_DEF,
    parameter int PROCS_PER_PARTITION = pwps_pkg::PROCS_PER_PARTITION_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wen,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    // input words
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_time_now,
    input  logic [1:0]  i_partition_index,
    input  logic [2:0]  i_process_index,
    input  logic [1:0]  i_process_state,
    input  logic [7:0]  i_priority_req,
    input  logic [31:0] i_tick_stamp,
    // result words
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_active_partition,
    output logic        o_switched,
    output logic [2:0]  o_selected_process,
    output logic        o_found
);
    import pwps_pkg::*;

    localparam int PW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int SW = (PROCS_PER_PARTITION > 1) ? $clog2(PROCS_PER_PARTITION) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Configuration registers
    logic [2:0]  r_part_count;
    logic [15:0] r_win [4];

    // Scheduler state
    logic [2:0]    r_state;
    logic [PW-1:0] r_active;
    logic [31:0]   r_deadline;
    logic [SW-1:0] r_run [NUM_PARTITIONS];
    logic [PW:0]   r_rem;
    logic          r_sw;
    logic          r_found;

    // Held input word
    logic [1:0]  r_op;
    logic [31:0] r_now;
    logic [1:0]  r_pidx;
    logic [2:0]  r_sidx;
    logic [1:0]  r_wstate;
    logic [7:0]  r_wprio;
    logic [31:0] r_wstamp;

    // Output register
    logic       r_out_vld;
    logic [1:0] r_out_part;
    logic       r_out_sw;
    logic [2:0] r_out_sel;
    logic       r_out_found;

    logic          w_pidx_ok;
    logic          w_sidx_ok;
    logic [PW-1:0] w_pidx;
    logic [PW:0]   w_cnt;
    logic [PW-1:0] w_run_addr;
    logic [SW-1:0] w_run_slot;
    logic          w_load;
    t_cell_cmd     w_cmd;
    t_token        w_tok [PROCS_PER_PARTITION + 1];

    assign w_pidx_ok = (32'(r_pidx) < 32'(NUM_PARTITIONS));
    assign w_sidx_ok = (32'(r_sidx) < 32'(PROCS_PER_PARTITION));
    assign w_pidx    = PW'(r_pidx);

    // Clamp the partition count to 1..NUM_PARTITIONS
    always_comb begin
        if (r_part_count == 3'd0) begin
            w_cnt = (PW+1)'(1);
        end else if (32'(r_part_count) > 32'(NUM_PARTITIONS)) begin
            w_cnt = (PW+1)'(NUM_PARTITIONS);
        end else begin
            w_cnt = (PW+1)'(r_part_count);
        end
    end

    // Single read port on the running slots
    assign w_run_addr = (r_state == S_DONE && r_op == OP_SELECT) ? w_pidx : r_active;
    assign w_run_slot = r_run[w_run_addr];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_count <= PART_COUNT_RST;
            r_win[0]     <= WINDOW_SHORT;
            r_win[1]     <= WINDOW_SHORT;
            r_win[2]     <= WINDOW_SHORT;
            r_win[3]     <= WINDOW_LONG;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                CFG_PART_COUNT: r_part_count <= i_cfg_wdata[2:0];
                CFG_WINDOW_0:   r_win[0]     <= i_cfg_wdata;
                CFG_WINDOW_1:   r_win[1]     <= i_cfg_wdata;
                CFG_WINDOW_2:   r_win[2]     <= i_cfg_wdata;
                CFG_WINDOW_3:   r_win[3]     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Broadcast table updates to the cells
    always_comb begin
        w_cmd       = '0;
        w_cmd.state = r_wstate;
        w_cmd.prio  = r_wprio;
        w_cmd.stamp = r_wstamp;
        if (r_state == S_EXEC && r_op == OP_WRITE) begin
            w_cmd.wr   = w_pidx_ok && w_sidx_ok;
            w_cmd.part = PART_IDX_W'(r_pidx);
            w_cmd.slot = SLOT_IDX_W'(r_sidx);
        end else if (r_state == S_EXEC && r_op == OP_STOP) begin
            w_cmd.clr  = 1'b1;
            w_cmd.part = PART_IDX_W'(r_active);
            w_cmd.slot = SLOT_IDX_W'(w_run_slot);
        end
    end

    // Launch a select token into the first cell
    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].valid = (r_state == S_EXEC) && (r_op == OP_SELECT) && w_pidx_ok;
        w_tok[0].part  = PART_IDX_W'(r_pidx);
    end

    // Row of slot cells
    for (genvar g = 0; g < PROCS_PER_PARTITION; g++) begin : g_cell
        pwps_cell #(
            .NUM_PARTITIONS (NUM_PARTITIONS),
            .CELL_IDX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_load = (r_state == S_DONE) && (!r_out_vld || i_ready);

    // Hold the accepted word
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op     <= i_operation;
            r_now    <= i_time_now;
            r_pidx   <= i_partition_index;
            r_sidx   <= i_process_index;
            r_wstate <= i_process_state;
            r_wprio  <= i_priority_req;
            r_wstamp <= i_tick_stamp;
        end
    end

    // Sequence one word through its operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_active   <= '0;
            r_deadline <= '0;
            r_rem      <= '0;
            r_sw       <= 1'b0;
            r_found    <= 1'b0;
            for (int p = 0; p < NUM_PARTITIONS; p++) begin
                r_run[p] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_found <= 1'b0;
                    if (r_op == OP_TIME_CHECK && r_deadline <= r_now) begin
                        r_sw    <= 1'b1;
                        r_rem   <= (PW+1)'(r_active) + (PW+1)'(1);
                        r_state <= S_MOD;
                    end else begin
                        r_sw <= 1'b0;
                        if (r_op == OP_SELECT && w_pidx_ok) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MOD: begin
                    // wrap the next partition by repeated subtraction
                    if (r_rem >= w_cnt) begin
                        r_rem <= r_rem - w_cnt;
                    end else begin
                        r_active   <= PW'(r_rem);
                        r_deadline <= r_now + 32'(r_win[r_rem[1:0]]);
                        r_state    <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (w_tok[PROCS_PER_PARTITION].valid) begin
                        if (w_tok[PROCS_PER_PARTITION].have) begin
                            r_run[w_pidx] <= SW'(w_tok[PROCS_PER_PARTITION].best);
                            r_found       <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register: load the result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_part  <= 2'(r_active);
            r_out_sw    <= r_sw;
            r_out_found <= r_found;
            if (r_op == OP_SELECT && !w_pidx_ok) begin
                r_out_sel <= 3'd0;
            end else begin
                r_out_sel <= 3'(w_run_slot);
            end
        end
    end

    assign o_ready            = (r_state == S_IDLE);
    assign o_valid            = r_out_vld;
    assign o_active_partition = r_out_part;
    assign o_switched         = r_out_sw;
    assign o_selected_process = r_out_sel;
    assign o_found            = r_out_found;

    // A token leaves the row only while a select waits for it
    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[PROCS_PER_PARTITION].valid |-> (r_state == S_SCAN))
        else $error("select token left the cell row outside a scan");

    // An accepted word starts execution in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_EXEC))
        else $error("accepted word did not start execution");

    // A result never reports both a switch and a found process
    a_sw_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_switched && o_found))
        else $error("result reports both switch and found");

    // The wrap value stays at most NUM_PARTITIONS during the wrap loop
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (32'(r_rem) <= 32'(NUM_PARTITIONS)))
        else $error("partition wrap value out of range");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pwps_pkg::*;

    // Process states that the package leaves unnamed
    localparam logic [1:0] PST_RUNNING = 2'd2;
    localparam logic [1:0] PST_WAITING = 2'd3;

    localparam int NPART  = 4;
    localparam int NSLOT  = 8;
    localparam int PHASE_WORDS = 260;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] time_now;
        logic [1:0]  part;
        logic [2:0]  slot;
        logic [1:0]  pstate;
        logic [7:0]  prio;
        logic [31:0] stamp;
    } sched_word_t;

    typedef struct packed {
        logic [1:0] active;
        logic       switched;
        logic [2:0] sel;
        logic       found;
    } sched_result_t;

    typedef struct packed {
        sched_word_t   w;
        logic          typed;
        sched_result_t r;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wen;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_wdata;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_operation;
    logic [31:0] i_time_now;
    logic [1:0]  i_partition_index;
    logic [2:0]  i_process_index;
    logic [1:0]  i_process_state;
    logic [7:0]  i_priority_req;
    logic [31:0] i_tick_stamp;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_active_partition;
    logic        o_switched;
    logic [2:0]  o_selected_process;
    logic        o_found;

    partition_window_process_scheduler_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wen          (i_cfg_wen),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_operation        (i_operation),
        .i_time_now         (i_time_now),
        .i_partition_index  (i_partition_index),
        .i_process_index    (i_process_index),
        .i_process_state    (i_process_state),
        .i_priority_req     (i_priority_req),
        .i_tick_stamp       (i_tick_stamp),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_active_partition (o_active_partition),
        .o_switched         (o_switched),
        .o_selected_process (o_selected_process),
        .o_found            (o_found)
    );

    // Scheduler shadow state
    logic [2:0]  cfg_count;
    logic [15:0] cfg_window [NPART];
    logic [1:0]  sh_active;
    logic [31:0] sh_deadline;
    logic [1:0]  sh_state [NPART*NSLOT];
    logic [7:0]  sh_prio [NPART*NSLOT];
    logic [31:0] sh_stamp [NPART*NSLOT];
    logic [2:0]  sh_running [NPART];

    sched_result_t pending_results [$];
    dir_row_t      dir_rows [$];
    int            err_count;
    logic [31:0]   sim_ms;
    logic          quiet;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Alternate between stretches with and without idling
    initial begin
        quiet <= 1'b0;
        forever begin
            repeat ($urandom_range(150, 500)) @(posedge i_clk);
            quiet <= ~quiet;
        end
    end

    function automatic void sched_reset();
        cfg_count   = PART_COUNT_RST;
        cfg_window[0] = WINDOW_SHORT;
        cfg_window[1] = WINDOW_SHORT;
        cfg_window[2] = WINDOW_SHORT;
        cfg_window[3] = WINDOW_LONG;
        sh_active   = '0;
        sh_deadline = '0;
        for (int i = 0; i < NPART*NSLOT; i++) begin
            sh_state[i] = ST_DORMANT;
            sh_prio[i]  = '0;
            sh_stamp[i] = '0;
        end
        for (int i = 0; i < NPART; i++) sh_running[i] = '0;
    endfunction

    // Advance the shadow scheduler by one word and return its result word
    function automatic sched_result_t schedule_step(sched_word_t w);
        sched_result_t r;
        int            n;
        int            base;
        int            e;
        int            best;
        bit            have;
        r = '0;
        case (w.op)
            OP_TIME_CHECK: begin
                if (sh_deadline <= w.time_now) begin
                    n = (cfg_count == 0) ? 1 : ((cfg_count > NPART) ? NPART : cfg_count);
                    sh_active   = 2'((sh_active + 1) % n);
                    sh_deadline = w.time_now + {16'd0, cfg_window[sh_active]};
                    r.switched  = 1'b1;
                end
                r.sel = sh_running[sh_active];
            end
            OP_WRITE: begin
                e = w.part * NSLOT + w.slot;
                sh_state[e] = w.pstate;
                sh_prio[e]  = w.prio;
                sh_stamp[e] = w.stamp;
                r.sel = sh_running[sh_active];
            end
            OP_SELECT: begin
                base = w.part * NSLOT;
                best = 0;
                have = 1'b0;
                for (int i = 0; i < NSLOT; i++) begin
                    e = base + i;
                    if (sh_state[e] == ST_READY) begin
                        if (!have) begin
                            best = i;
                            have = 1'b1;
                        end else if (sh_prio[e] > sh_prio[base+best] ||
                                     (sh_prio[e] == sh_prio[base+best] &&
                                      sh_stamp[e] < sh_stamp[base+best])) begin
                            best = i;
                        end
                    end
                end
                if (have) begin
                    sh_running[w.part] = 3'(best);
                    r.found = 1'b1;
                end
                r.sel = sh_running[w.part];
            end
            default: begin
                sh_state[sh_active*NSLOT + sh_running[sh_active]] = ST_DORMANT;
                r.sel = sh_running[sh_active];
            end
        endcase
        r.active = sh_active;
        return r;
    endfunction

    function automatic dir_row_t drow(logic [1:0] op, logic [31:0] now, logic [1:0] part,
                                      logic [2:0] slot, logic [1:0] st, logic [7:0] prio,
                                      logic [31:0] stamp, logic typed, logic [1:0] act,
                                      logic sw, logic [2:0] sel, logic fnd);
        dir_row_t d;
        d.w = '{op, now, part, slot, st, prio, stamp};
        d.typed = typed;
        d.r = '{act, sw, sel, fnd};
        return d;
    endfunction

    // Random word, mostly with time moving forward so windows expire
    function automatic sched_word_t random_word();
        sched_word_t w;
        int          k;
        w.time_now = $urandom;
        w.part     = 2'($urandom_range(0, 3));
        w.slot     = 3'($urandom_range(0, 7));
        w.pstate   = 2'($urandom_range(0, 3));
        w.prio     = 8'($urandom_range(0, 255));
        w.stamp    = $urandom;
        k = $urandom_range(0, 99);
        if (k < 35)      w.op = OP_WRITE;
        else if (k < 65) w.op = OP_SELECT;
        else if (k < 90) w.op = OP_TIME_CHECK;
        else             w.op = OP_STOP;
        if (w.op == OP_WRITE) begin
            if ($urandom_range(0, 99) < 55) w.pstate = ST_READY;
            if ($urandom_range(0, 1) == 0) w.prio = 8'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0) w.stamp = $urandom_range(0, 7);
        end
        if (w.op == OP_TIME_CHECK) begin
            k = $urandom_range(0, 99);
            if (k < 50)      sim_ms = sim_ms + $urandom_range(0, 1500);
            else if (k < 85) sim_ms = sim_ms + $urandom_range(0, 70000);
            else if (k < 92) sim_ms = $urandom;
            if (k < 92) w.time_now = sim_ms;
        end
        return w;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (quiet || k < 60) return 0;
        if (k < 96) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Present one word, wait for it to be taken, then record its expected result
    task automatic send_word(sched_word_t w, logic typed, sched_result_t typed_res);
        int            gap;
        sched_result_t r;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_operation       <= w.op;
        i_time_now        <= w.time_now;
        i_partition_index <= w.part;
        i_process_index   <= w.slot;
        i_process_state   <= w.pstate;
        i_priority_req    <= w.prio;
        i_tick_stamp      <= w.stamp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        r = schedule_step(w);
        if (typed) r = typed_res;
        pending_results.push_back(r);
    endtask

    // Drain the block before touching its registers
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        if (idx == CFG_PART_COUNT) cfg_count = data[2:0];
        else if (idx <= CFG_WINDOW_3) cfg_window[idx - CFG_WINDOW_0] = data;
    endtask

    task automatic write_all(logic [15:0] cnt, logic [15:0] w0, logic [15:0] w1,
                             logic [15:0] w2, logic [15:0] w3);
        write_reg(CFG_PART_COUNT, cnt);
        write_reg(CFG_WINDOW_0, w0);
        write_reg(CFG_WINDOW_1, w1);
        write_reg(CFG_WINDOW_2, w2);
        write_reg(CFG_WINDOW_3, w3);
    endtask

    // Drive the result side with random stalls
    initial begin
        int stall_left;
        int k;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                k = $urandom_range(0, 99);
                if (!quiet && k < 20) stall_left = $urandom_range(1, 3);
                else if (!quiet && k < 22) stall_left = $urandom_range(20, 60);
            end
        end
    end

    function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            err_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
        end
    endfunction

    // Compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        sched_result_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t: result word with no pending expectation", $time);
            end else begin
                e = pending_results.pop_front();
                cmp_field("active_partition", 32'(e.active), 32'(o_active_partition));
                cmp_field("switched", 32'(e.switched), 32'(o_switched));
                cmp_field("selected_process", 32'(e.sel), 32'(o_selected_process));
                cmp_field("found", 32'(e.found), 32'(o_found));
            end
        end
    end

    // Main sequence
    initial begin
        int          guard;
        logic [15:0] junk;
        err_count = 0;
        sim_ms    = 32'd0;
        sched_reset();
        i_rst_n           <= 1'b0;
        i_cfg_wen         <= 1'b0;
        i_cfg_index       <= '0;
        i_cfg_wdata       <= '0;
        i_valid           <= 1'b0;
        i_operation       <= '0;
        i_time_now        <= '0;
        i_partition_index <= '0;
        i_process_index   <= '0;
        i_process_state   <= '0;
        i_priority_req    <= '0;
        i_tick_stamp      <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        //                 op             time_now      pt slot state        prio   stamp
        //                 typed act sw sel fnd
        // Window expiry right at the deadline, then just before it and at it again
        dir_rows.push_back(drow(OP_TIME_CHECK, 32'd0,        0, 0, ST_DORMANT, 8'd0,   32'd0,
                                1, 1, 1, 0, 0));
        dir_rows.push_back(drow(OP_TIME_CHECK, 32'd999,      0, 0, ST_DORMANT, 8'd0,   32'd0,
                                1, 1, 0, 0, 0));
        dir_rows.push_back(drow(OP_TIME_CHECK, 32'd1000,     0, 0, ST_DORMANT, 8'd0,   32'd0,
                                1, 2, 1, 0, 0));
        // Select with nothing ready
        dir_rows.push_back(drow(OP_SELECT,     32'd0,        0, 0, ST_DORMANT, 8'd0,   32'd0,
                                1, 2, 0, 0, 0));
        dir_rows.push_back(drow(OP_WRITE,      32'hFFFFFFFF, 0, 7, ST_READY,   8'd255,
                                32'hFFFFFFFF, 1, 2, 0, 0, 0));
        dir_rows.push_back(drow(OP_WRITE,      32'd0,        0, 3, ST_READY,   8'd255, 32'd5,
                                0, 0, 0, 0, 0));
        // Older stamp but lower priority must lose
        dir_rows.push_back(drow(OP_WRITE,      32'd0,        0, 1, ST_READY,   8'd10,  32'd0,
                                0, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_SELECT,     32'd0,        0, 0, ST_DORMANT, 8'd0,   32'd0,
                                1, 2, 0, 3, 1));
        // Equal priority and stamp: lowest slot wins
        dir_rows.push_back(drow(OP_WRITE,      32'd0,        0, 5, ST_READY,   8'd255, 32'd5,
                                0, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_SELECT,     32'd0,        0, 0, ST_DORMANT, 8'd0,   32'd0,
                                0, 0, 0, 0, 0));
        // Waiting and running entries are never picked
        dir_rows.push_back(drow(OP_WRITE,      32'd0,        0, 0, PST_WAITING, 8'd255, 32'd0,
                                0, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_WRITE,      32'd0,        0, 2, PST_RUNNING, 8'd255, 32'd0,
                                0, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_SELECT,     32'd0,        0, 0, ST_DORMANT, 8'd0,   32'd0,
                                0, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_STOP,       32'd0,        0, 0, ST_DORMANT, 8'd0,   32'd0,
                                1, 2, 0, 0, 0));
        // Deadline wraps past the top of the tick counter
        dir_rows.push_back(drow(OP_TIME_CHECK, 32'hFFFFFFFF, 0, 0, ST_DORMANT, 8'd0,   32'd0,
                                1, 3, 1, 0, 0));
        dir_rows.push_back(drow(OP_TIME_CHECK, 32'd2998,     0, 0, ST_DORMANT, 8'd0,   32'd0,
                                1, 3, 0, 0, 0));
        // Round robin wraps back to partition zero
        dir_rows.push_back(drow(OP_TIME_CHECK, 32'd2999,     0, 0, ST_DORMANT, 8'd0,   32'd0,
                                1, 0, 1, 3, 0));
        dir_rows.push_back(drow(OP_STOP,       32'd0,        3, 7, ST_READY,   8'd0,   32'd0,
                                1, 0, 0, 3, 0));
        dir_rows.push_back(drow(OP_SELECT,     32'd0,        0, 0, ST_DORMANT, 8'd0,   32'd0,
                                1, 0, 0, 5, 1));
        // Lone ready process is recorded as running
        dir_rows.push_back(drow(OP_WRITE,      32'd0,        3, 6, ST_READY,   8'd0,   32'd0,
                                1, 0, 0, 5, 0));
        dir_rows.push_back(drow(OP_SELECT,     32'd0,        3, 0, ST_DORMANT, 8'd0,   32'd0,
                                1, 0, 0, 6, 1));
        dir_rows.push_back(drow(OP_SELECT,     32'd0,        1, 0, ST_DORMANT, 8'd0,   32'd0,
                                1, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_WRITE,      32'd0,        1, 0, ST_READY,   8'd0,
                                32'hFFFFFFFF, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_WRITE,      32'd0,        1, 1, ST_READY,   8'd0,
                                32'hFFFFFFFF, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(OP_SELECT,     32'd3998,     1, 0, ST_DORMANT, 8'd0,   32'd0,
                                0, 0, 0, 0, 0));

        foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);
        sim_ms = 32'd4000;

        // Random phases under different register settings
        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                wait_idle();
                case (p)
                    1: write_all(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0);
                    2: write_all(16'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                    3: write_all(16'd1, 16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom));
                    4: write_all(16'd2, 16'($urandom_range(0, 3000)),
                                 16'($urandom_range(0, 3000)), 16'($urandom), 16'($urandom));
                    5: begin
                        junk = 16'($urandom);
                        write_all(16'($urandom_range(3, 6)), 16'($urandom_range(0, 5000)),
                                  16'($urandom_range(0, 5000)), 16'($urandom_range(0, 5000)),
                                  16'($urandom_range(0, 5000)));
                        write_reg(3'(CFG_WINDOW_3 + $urandom_range(1, 3)), junk);
                    end
                    default: write_all(16'd4, 16'($urandom_range(0, 20)),
                                       16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                                       16'($urandom_range(0, 20)));
                endcase
                i_cfg_wen <= 1'b0;
            end
            for (int n = 0; n < PHASE_WORDS; n++) send_word(random_word(), 1'b0, '0);
        end

        // Drain and let the block settle
        i_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_results.size() != 0) begin
            err_count++;
            $display("%0t: %0d expected result words never arrived",
                     $time, pending_results.size());
        end
        repeat (30) @(posedge i_clk);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
